[sv/msl_pkg.sv]
// ----------------------------------------------------------------------------
// msl_pkg: shared types and constants for the servo slew limiter
// Field widths, register indexes, reset values and the scaling constants
// used by the sequencer, the channel state store and the shared multiplier.
// ----------------------------------------------------------------------------
package msl_pkg;

  localparam int NUM_CHANNELS_DEF = 16;

  localparam int IDX_W   = 4;
  localparam int ANGLE_W = 8;
  localparam int PULSE_W = 12;
  localparam int DELAY_W = 8;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 12;
  localparam int CFGI_W  = 2;

  localparam logic [ANGLE_W-1:0] FULL_ANGLE  = 8'd180;
  localparam logic [ANGLE_W-1:0] START_ANGLE = 8'd90;

  localparam logic [IDX_W-1:0]   NUM_SERVOS_RST = 4'd0;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = 12'd150;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = 12'd600;
  localparam logic [DELAY_W-1:0] STEP_DELAY_RST = 8'd10;

  // x / 180 == (x * RECIP) >> RECIP_SH for every x below 2^20
  localparam int MULA_W   = 20;
  localparam int MULB_W   = 21;
  localparam int PROD_W   = MULA_W + MULB_W;
  localparam int RECIP_SH = 28;
  localparam logic [MULB_W-1:0] RECIP = 21'd1491309;

  localparam logic [CFGI_W-1:0] REG_NUM_SERVOS = 2'd0;
  localparam logic [CFGI_W-1:0] REG_MIN_PULSE  = 2'd1;
  localparam logic [CFGI_W-1:0] REG_MAX_PULSE  = 2'd2;
  localparam logic [CFGI_W-1:0] REG_STEP_DELAY = 2'd3;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SET    = 1'b1;

  typedef enum logic {
    MUL_ANGLE,
    MUL_RECIP
  } mul_sel_e;

  typedef struct packed {
    logic rd_en;
    logic cur_we;
    logic goal_we;
    logic start_we;
    logic set_moving;
    logic clr_moving;
    logic set_wait;
    logic clr_wait;
  } st_ctrl_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] cur;
    logic [ANGLE_W-1:0] goal;
    logic [TIME_W-1:0]  start;
    logic               moving;
    logic               waiting;
  } st_rd_t;

endpackage

[sv/msl_state_store.sv]
// ----------------------------------------------------------------------------
// msl_state_store: per-channel servo state
// Angle and timestamp memories with per-entry valid bits, moving and
// waiting flags; one registered read port and one write port.
// ----------------------------------------------------------------------------
module msl_state_store #(
  parameter int NUM_CHANNELS = 16,
  parameter int CH_W         = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  msl_pkg::st_ctrl_t           ctrl_i,
  input  logic [CH_W-1:0]             rd_addr_i,
  input  logic [CH_W-1:0]             wr_addr_i,
  input  logic [msl_pkg::ANGLE_W-1:0] wr_cur_i,
  input  logic [msl_pkg::ANGLE_W-1:0] wr_goal_i,
  input  logic [msl_pkg::TIME_W-1:0]  wr_start_i,
  output msl_pkg::st_rd_t             rd_o
);
  import msl_pkg::*;

  logic [ANGLE_W-1:0] cur_mem   [NUM_CHANNELS];
  logic [ANGLE_W-1:0] goal_mem  [NUM_CHANNELS];
  logic [TIME_W-1:0]  start_mem [NUM_CHANNELS];

  logic [NUM_CHANNELS-1:0] cur_vld_q, goal_vld_q, start_vld_q;
  logic [NUM_CHANNELS-1:0] moving_q, waiting_q;

  logic [ANGLE_W-1:0] cur_raw_q, goal_raw_q;
  logic [TIME_W-1:0]  start_raw_q;
  logic               cur_v_q, goal_v_q, start_v_q, moving_rd_q, waiting_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cur_we) begin
      cur_mem[wr_addr_i] <= wr_cur_i;
    end
    if (ctrl_i.goal_we) begin
      goal_mem[wr_addr_i] <= wr_goal_i;
    end
    if (ctrl_i.start_we) begin
      start_mem[wr_addr_i] <= wr_start_i;
    end
    if (ctrl_i.rd_en) begin
      cur_raw_q   <= cur_mem[rd_addr_i];
      goal_raw_q  <= goal_mem[rd_addr_i];
      start_raw_q <= start_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q    <= '0;
      goal_vld_q   <= '0;
      start_vld_q  <= '0;
      moving_q     <= '0;
      waiting_q    <= '0;
      cur_v_q      <= 1'b0;
      goal_v_q     <= 1'b0;
      start_v_q    <= 1'b0;
      moving_rd_q  <= 1'b0;
      waiting_rd_q <= 1'b0;
    end else begin
      if (ctrl_i.cur_we) begin
        cur_vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.goal_we) begin
        goal_vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.start_we) begin
        start_vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.set_moving) begin
        moving_q[wr_addr_i] <= 1'b1;
      end else if (ctrl_i.clr_moving) begin
        moving_q[wr_addr_i] <= 1'b0;
      end
      if (ctrl_i.set_wait) begin
        waiting_q[wr_addr_i] <= 1'b1;
      end else if (ctrl_i.clr_wait) begin
        waiting_q[wr_addr_i] <= 1'b0;
      end
      if (ctrl_i.rd_en) begin
        cur_v_q      <= cur_vld_q[rd_addr_i];
        goal_v_q     <= goal_vld_q[rd_addr_i];
        start_v_q    <= start_vld_q[rd_addr_i];
        moving_rd_q  <= moving_q[rd_addr_i];
        waiting_rd_q <= waiting_q[rd_addr_i];
      end
    end
  end

  always_comb begin
    rd_o.cur     = cur_v_q   ? cur_raw_q   : START_ANGLE;
    rd_o.goal    = goal_v_q  ? goal_raw_q  : START_ANGLE;
    rd_o.start   = start_v_q ? start_raw_q : '0;
    rd_o.moving  = moving_rd_q;
    rd_o.waiting = waiting_rd_q;
  end

endmodule

[sv/msl_scaler.sv]
// ----------------------------------------------------------------------------
// msl_scaler: shared multiplier for angle to pulse scaling
// Pass one forms angle * |span|, pass two multiplies that by the reciprocal
// of 180; the top bits give the truncated quotient.
// ----------------------------------------------------------------------------
module msl_scaler (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  msl_pkg::mul_sel_e           sel_i,
  input  logic [msl_pkg::ANGLE_W-1:0] angle_i,
  input  logic [msl_pkg::PULSE_W-1:0] span_i,
  output logic [msl_pkg::PULSE_W-1:0] quot_o
);
  import msl_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic [MULA_W-1:0] op_a;
  logic [MULB_W-1:0] op_b;

  always_comb begin
    unique case (sel_i)
      MUL_ANGLE: begin
        op_a = MULA_W'(angle_i);
        op_b = MULB_W'(span_i);
      end
      MUL_RECIP: begin
        op_a = prod_q[MULA_W-1:0];
        op_b = RECIP;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  assign quot_o = prod_q[RECIP_SH+PULSE_W-1:RECIP_SH];

endmodule

[sv/multi_servo_slew_limiter_core.sv]
// ----------------------------------------------------------------------------
// multi_servo_slew_limiter_core: multi-channel servo slew limiter
// Set-target requests store a goal per channel; update requests walk the
// active channels, step each due channel one degree and emit its pulse width.
// ----------------------------------------------------------------------------
// Channel | Signals                                          | Direction
// cfg     | cfg_we_i cfg_idx_i cfg_data_i                    | in, write only
// in      | in_valid_i/in_ready_o, opcode, index, angle, now | in
// out     | out_valid_o/out_ready_i, channel, pulse, last    | out
//
// Set-target request: taken while idle and written to the addressed channel.
// Update request: each skipped channel passes S_RD and S_EV, each stepped
//   channel also S_M1, S_M2 and S_OUT, and S_FIN hands over the last result;
//   with no active channels the request is accepted and the core stays idle.
// Reset: asynchronous; channel state reads as reset values until written.
// A stalled output holds the sequencer only when a result is already pending behind it.
module multi_servo_slew_limiter_core #(
  parameter int NUM_CHANNELS = msl_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [msl_pkg::CFGI_W-1:0]  cfg_idx_i,
  input  logic [msl_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic [msl_pkg::IDX_W-1:0]   servo_index_i,
  input  logic [msl_pkg::ANGLE_W-1:0] target_angle_i,
  input  logic [msl_pkg::TIME_W-1:0]  now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [msl_pkg::IDX_W-1:0]   servo_channel_o,
  output logic [msl_pkg::PULSE_W-1:0] pulse_width_o,
  output logic                        last_o
);
  import msl_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_M1,
    S_M2,
    S_OUT,
    S_FIN
  } state_e;

  state_e state_q;

  logic [IDX_W-1:0]   num_servos_q;
  logic [PULSE_W-1:0] min_pulse_q, max_pulse_q;
  logic [DELAY_W-1:0] step_delay_q;

  logic [IDX_W-1:0]   ch_q, count_q;
  logic [TIME_W-1:0]  now_q;
  logic [ANGLE_W-1:0] ang_q;

  logic               pend_vld_q;
  logic [IDX_W-1:0]   pend_ch_q;
  logic [PULSE_W-1:0] pend_pw_q;

  logic               out_vld_q, out_last_q;
  logic [IDX_W-1:0]   out_ch_q;
  logic [PULSE_W-1:0] out_pw_q;

  st_ctrl_t           st_ctrl;
  st_rd_t             st_rd;
  logic [CH_W-1:0]    ch_addr, wr_addr;
  logic [ANGLE_W-1:0] step_ang, goal_clamp;
  logic [TIME_W-1:0]  wr_start;

  logic               accept, set_ok, do_step, expired, last_ch, out_free, push_ok;
  logic               out_load;
  logic [IDX_W-1:0]   count_new;
  logic               span_neg;
  logic [PULSE_W-1:0] span_abs, quot, pulse;
  logic               mul_en;
  mul_sel_e           mul_sel;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign set_ok     = (32'(servo_index_i) < NUM_CHANNELS);
  assign ch_addr    = CH_W'(ch_q);
  assign goal_clamp = (target_angle_i > FULL_ANGLE) ? FULL_ANGLE : target_angle_i;
  assign count_new  = (32'(num_servos_q) > NUM_CHANNELS) ? IDX_W'(NUM_CHANNELS)
                                                          : num_servos_q;

  assign do_step  = st_rd.moving && (st_rd.cur != st_rd.goal) && !st_rd.waiting;
  assign expired  = ((now_q - st_rd.start) >= TIME_W'(step_delay_q));
  assign step_ang = (st_rd.goal > st_rd.cur) ? st_rd.cur + 8'd1 : st_rd.cur - 8'd1;
  assign last_ch  = (ch_q == count_q - 4'd1);
  assign out_free = !out_vld_q || out_ready_i;
  assign push_ok  = !pend_vld_q || out_free;
  assign out_load = pend_vld_q && out_free && ((state_q == S_OUT) || (state_q == S_FIN));

  assign span_neg = (max_pulse_q < min_pulse_q);
  assign span_abs = span_neg ? min_pulse_q - max_pulse_q : max_pulse_q - min_pulse_q;
  assign pulse    = span_neg ? min_pulse_q - quot : min_pulse_q + quot;

  always_comb begin
    st_ctrl  = '0;
    wr_addr  = ch_addr;
    wr_start = now_q;
    unique case (state_q)
      S_IDLE: begin
        wr_addr  = CH_W'(servo_index_i);
        wr_start = now_ms_i;
        if (accept && opcode_i == OP_SET && set_ok) begin
          st_ctrl.goal_we    = 1'b1;
          st_ctrl.start_we   = 1'b1;
          st_ctrl.set_moving = 1'b1;
        end
      end
      S_RD: st_ctrl.rd_en = 1'b1;
      S_EV: begin
        if (st_rd.moving && (st_rd.cur != st_rd.goal)) begin
          if (!st_rd.waiting) begin
            st_ctrl.cur_we     = 1'b1;
            st_ctrl.start_we   = 1'b1;
            st_ctrl.set_wait   = 1'b1;
            st_ctrl.clr_moving = (step_ang == st_rd.goal);
          end else if (expired) begin
            st_ctrl.clr_wait = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_en  = 1'b0;
    mul_sel = MUL_ANGLE;
    unique case (state_q)
      S_M1: mul_en = 1'b1;
      S_M2: begin
        mul_en  = 1'b1;
        mul_sel = MUL_RECIP;
      end
      default: ;
    endcase
  end

  msl_state_store #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .CH_W         (CH_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (st_ctrl),
    .rd_addr_i  (ch_addr),
    .wr_addr_i  (wr_addr),
    .wr_cur_i   (step_ang),
    .wr_goal_i  (goal_clamp),
    .wr_start_i (wr_start),
    .rd_o       (st_rd)
  );

  msl_scaler u_scaler (
    .clk_i   (clk_i),
    .en_i    (mul_en),
    .sel_i   (mul_sel),
    .angle_i (ang_q),
    .span_i  (span_abs),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_servos_q <= NUM_SERVOS_RST;
      min_pulse_q  <= MIN_PULSE_RST;
      max_pulse_q  <= MAX_PULSE_RST;
      step_delay_q <= STEP_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_SERVOS: num_servos_q <= cfg_data_i[IDX_W-1:0];
        REG_MIN_PULSE:  min_pulse_q  <= cfg_data_i[PULSE_W-1:0];
        REG_MAX_PULSE:  max_pulse_q  <= cfg_data_i[PULSE_W-1:0];
        REG_STEP_DELAY: step_delay_q <= cfg_data_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ch_q       <= '0;
      count_q    <= '0;
      now_q      <= '0;
      ang_q      <= '0;
      pend_vld_q <= 1'b0;
      pend_ch_q  <= '0;
      pend_pw_q  <= '0;
      out_vld_q  <= 1'b0;
      out_ch_q   <= '0;
      out_pw_q   <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q  <= 1'b1;
        out_ch_q   <= pend_ch_q;
        out_pw_q   <= pend_pw_q;
        out_last_q <= (state_q == S_FIN);
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && opcode_i == OP_UPDATE) begin
            now_q   <= now_ms_i;
            ch_q    <= '0;
            count_q <= count_new;
            if (count_new != '0) begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: state_q <= S_EV;
        S_EV: begin
          ang_q <= step_ang;
          if (do_step) begin
            state_q <= S_M1;
          end else if (last_ch) begin
            state_q <= S_FIN;
          end else begin
            ch_q    <= ch_q + 4'd1;
            state_q <= S_RD;
          end
        end
        S_M1: state_q <= S_M2;
        S_M2: state_q <= S_OUT;
        S_OUT: begin
          if (push_ok) begin
            pend_vld_q <= 1'b1;
            pend_ch_q  <= ch_q;
            pend_pw_q  <= pulse;
            if (last_ch) begin
              state_q <= S_FIN;
            end else begin
              ch_q    <= ch_q + 4'd1;
              state_q <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (!pend_vld_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            pend_vld_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_vld_q;
  assign servo_channel_o = out_ch_q;
  assign pulse_width_o   = out_pw_q;
  assign last_o          = out_last_q;

endmodule
